// File: rtl/bs_pkg.sv
`default_nettype none

package bs_pkg;

  localparam int TABLE_DEPTH = 1024;
  localparam int DATA_W      = 32;
  localparam int ADDR_W      = $clog2(TABLE_DEPTH);
  localparam int SIZE_W      = $clog2(TABLE_DEPTH + 1);
  localparam int LH_W        = SIZE_W + 1;
  localparam int IDX_W       = 10;
  localparam int CNT_W       = 5;
  localparam int TSIZE_W     = 11;
  localparam int PADDR_W     = 3;

  localparam logic FUNC_WRITE  = 1'b0;
  localparam logic FUNC_SEARCH = 1'b1;

  localparam logic [PADDR_W-3:0] REG_TABLE_SIZE = '0;

  typedef struct packed {
    logic wr;
    logic start;
    logic rd;
    logic cmp;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic more;
  } status_t;

endpackage

`default_nettype wire

// File: rtl/bs_ram.sv
`default_nettype none

module bs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

// File: rtl/bs_dpath.sv
`default_nettype none

module bs_dpath (
  input  wire logic                          clk_i,
  input  wire bs_pkg::cmd_t                  cmd_i,
  input  wire logic [bs_pkg::IDX_W-1:0]      entry_index_i,
  input  wire logic signed [bs_pkg::DATA_W-1:0] entry_value_i,
  input  wire logic signed [bs_pkg::DATA_W-1:0] search_key_i,
  input  wire logic [bs_pkg::TSIZE_W-1:0]    table_size_i,
  output bs_pkg::status_t                    status_o,
  output logic                               found_o,
  output logic [bs_pkg::IDX_W-1:0]           match_index_o,
  output logic [bs_pkg::CNT_W-1:0]           comparison_count_o
);

  logic signed [bs_pkg::DATA_W-1:0] key_q, key_d;
  logic [bs_pkg::LH_W-1:0]          lo_q, lo_d, hi_q, hi_d;
  logic [bs_pkg::ADDR_W-1:0]        mid_q, mid_d, where_q, where_d;
  logic [bs_pkg::CNT_W-1:0]         cnt_q, cnt_d;
  logic                             hit_q, hit_d;
  logic                             found_q, found_d;
  logic [bs_pkg::IDX_W-1:0]         idx_q, idx_d;
  logic [bs_pkg::CNT_W-1:0]         rcnt_q, rcnt_d;

  logic [bs_pkg::LH_W-1:0]   diff;
  logic [bs_pkg::LH_W-1:0]   mid_full;
  logic [bs_pkg::ADDR_W-1:0] mid;
  logic [bs_pkg::SIZE_W-1:0] n;
  logic [bs_pkg::DATA_W-1:0] rdata;
  logic                      wr_en;

  assign diff     = hi_q - lo_q;
  assign mid_full = lo_q + (diff >> 1);
  assign mid      = mid_full[bs_pkg::ADDR_W-1:0];
  assign wr_en    = cmd_i.wr && (32'(entry_index_i) < 32'(bs_pkg::TABLE_DEPTH));

  assign status_o.more = ($signed(lo_q) <= $signed(hi_q)) && !hit_q;

  always_comb begin
    if (32'(table_size_i) > 32'(bs_pkg::TABLE_DEPTH)) begin
      n = bs_pkg::SIZE_W'(bs_pkg::TABLE_DEPTH);
    end else begin
      n = bs_pkg::SIZE_W'(table_size_i);
    end
  end

  bs_ram #(
    .WIDTH (bs_pkg::DATA_W),
    .DEPTH (bs_pkg::TABLE_DEPTH)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (bs_pkg::ADDR_W'(entry_index_i)),
    .wdata_i (entry_value_i),
    .re_i    (cmd_i.rd),
    .raddr_i (mid),
    .rdata_o (rdata)
  );

  always_comb begin
    key_d   = key_q;
    lo_d    = lo_q;
    hi_d    = hi_q;
    mid_d   = mid_q;
    where_d = where_q;
    cnt_d   = cnt_q;
    hit_d   = hit_q;
    found_d = found_q;
    idx_d   = idx_q;
    rcnt_d  = rcnt_q;
    if (cmd_i.start) begin
      key_d   = search_key_i;
      lo_d    = '0;
      hi_d    = bs_pkg::LH_W'(n) - bs_pkg::LH_W'(1);
      cnt_d   = '0;
      hit_d   = 1'b0;
      where_d = '0;
    end
    if (cmd_i.rd) begin
      mid_d = mid;
    end
    if (cmd_i.cmp) begin
      if ($signed(rdata) == key_q) begin
        hit_d   = 1'b1;
        where_d = mid_q;
        cnt_d   = cnt_q + bs_pkg::CNT_W'(1);
      end else begin
        cnt_d = cnt_q + bs_pkg::CNT_W'(2);
        if (key_q < $signed(rdata)) begin
          hi_d = bs_pkg::LH_W'(mid_q) - bs_pkg::LH_W'(1);
        end else begin
          lo_d = bs_pkg::LH_W'(mid_q) + bs_pkg::LH_W'(1);
        end
      end
    end
    if (cmd_i.emit) begin
      found_d = hit_q;
      idx_d   = hit_q ? bs_pkg::IDX_W'(where_q) : '0;
      rcnt_d  = cnt_q;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q   <= key_d;
    lo_q    <= lo_d;
    hi_q    <= hi_d;
    mid_q   <= mid_d;
    where_q <= where_d;
    cnt_q   <= cnt_d;
    hit_q   <= hit_d;
    found_q <= found_d;
    idx_q   <= idx_d;
    rcnt_q  <= rcnt_d;
  end

  assign found_o            = found_q;
  assign match_index_o      = idx_q;
  assign comparison_count_o = rcnt_q;

endmodule

`default_nettype wire

// File: rtl/bs_ctrl.sv
`default_nettype none

module bs_ctrl (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            in_valid_i,
  input  wire logic            in_func_i,
  output logic                 in_ready_o,
  output logic                 out_valid_o,
  input  wire logic            out_ready_i,
  input  wire bs_pkg::status_t status_i,
  output bs_pkg::cmd_t         cmd_o
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_PROBE = 2'd1;
  localparam logic [1:0] ST_CMP   = 2'd2;
  localparam logic [1:0] ST_DONE  = 2'd3;

  logic [1:0] state_q, state_d;
  logic       ovalid_q, ovalid_d;
  logic       accept;
  logic       slot_free;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign accept      = in_valid_i && in_ready_o;
  assign slot_free   = !ovalid_q || out_ready_i;
  assign out_valid_o = ovalid_q;

  always_comb begin
    state_d     = state_q;
    ovalid_d    = ovalid_q && !out_ready_i;
    cmd_o       = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (in_func_i == bs_pkg::FUNC_SEARCH) begin
            cmd_o.start = 1'b1;
            state_d     = ST_PROBE;
          end else begin
            cmd_o.wr = 1'b1;
          end
        end
      end
      ST_PROBE: begin
        if (status_i.more) begin
          cmd_o.rd = 1'b1;
          state_d  = ST_CMP;
        end else begin
          state_d = ST_DONE;
        end
      end
      ST_CMP: begin
        cmd_o.cmp = 1'b1;
        state_d   = ST_PROBE;
      end
      ST_DONE: begin
        if (slot_free) begin
          cmd_o.emit = 1'b1;
          ovalid_d   = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      ovalid_q <= ovalid_d;
    end
  end

endmodule

`default_nettype wire

// File: rtl/binary_search_with_probe_count_top.sv
`default_nettype none

// channel   dir  handshake                 payload
// s_axis    in   s_axis_tvalid/tready      tuser func, tdata index/value/key
// m_axis    out  m_axis_tvalid/tready      tuser found, tdata index/count
// apb       in   psel/penable/pwrite       table_size at address 0
//
// a write item is written in the idle state; a search loops through a probe
// state (registered table read) and a compare state, then waits in done
// reset clears the controller, the result valid and table_size; table contents
// are undefined until written
// a waiting result sits in the output register and holds the next search at
// its end; write items keep flowing meanwhile

module binary_search_with_probe_count_top (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        s_axis_tvalid_i,
  output logic                             s_axis_tready_o,
  // [9:0] entry_index, [41:10] entry_value, [73:42] search_key, rest zero
  input  wire logic [79:0]                 s_axis_tdata_i,
  // [0] func
  input  wire logic                        s_axis_tuser_i,
  output logic                             m_axis_tvalid_o,
  input  wire logic                        m_axis_tready_i,
  // [9:0] match_index, [14:10] comparison_count, [15] zero
  output logic [15:0]                      m_axis_tdata_o,
  // [0] found
  output logic                             m_axis_tuser_o,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [bs_pkg::PADDR_W-1:0]  paddr,
  input  wire logic [31:0]                 pwdata,
  output logic [31:0]                      prdata,
  output logic                             pready
);

  logic [bs_pkg::TSIZE_W-1:0] table_size_q, table_size_d;
  logic                       reg_sel;
  bs_pkg::cmd_t               cmd;
  bs_pkg::status_t            status;
  logic                       found;
  logic [bs_pkg::IDX_W-1:0]   match_index;
  logic [bs_pkg::CNT_W-1:0]   comparison_count;

  assign pready  = 1'b1;
  assign reg_sel = (paddr[bs_pkg::PADDR_W-1:2] == bs_pkg::REG_TABLE_SIZE);
  assign prdata  = reg_sel ? 32'(table_size_q) : 32'd0;

  always_comb begin
    table_size_d = table_size_q;
    if (psel && penable && pwrite && pready && reg_sel) begin
      table_size_d = pwdata[bs_pkg::TSIZE_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      table_size_q <= '0;
    end else begin
      table_size_q <= table_size_d;
    end
  end

  bs_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_func_i   (s_axis_tuser_i),
    .in_ready_o  (s_axis_tready_o),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  bs_dpath u_dpath (
    .clk_i              (clk_i),
    .cmd_i              (cmd),
    .entry_index_i      (s_axis_tdata_i[9:0]),
    .entry_value_i      (s_axis_tdata_i[41:10]),
    .search_key_i       (s_axis_tdata_i[73:42]),
    .table_size_i       (table_size_q),
    .status_o           (status),
    .found_o            (found),
    .match_index_o      (match_index),
    .comparison_count_o (comparison_count)
  );

  assign m_axis_tdata_o = {1'b0, comparison_count, match_index};
  assign m_axis_tuser_o = found;

endmodule

`default_nettype wire

// File: verif/binary_search_monitor.sv
`timescale 1ns / 100ps

module binary_search_monitor
  import bs_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               s_axis_tvalid_i,
  input  logic               s_axis_tready_i,
  // [9:0] entry_index, [41:10] entry_value, [73:42] search_key, rest zero
  input  logic [79:0]        s_axis_tdata_i,
  // [0] func
  input  logic               s_axis_tuser_i,
  input  logic               m_axis_tvalid_i,
  input  logic               m_axis_tready_i,
  // [9:0] match_index, [14:10] comparison_count, [15] zero
  input  logic [15:0]        m_axis_tdata_i,
  // [0] found
  input  logic               m_axis_tuser_i,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [31:0]        pwdata,
  input  logic               pready,
  output int                 fail_count_o,
  output int                 pending_o
);

  typedef struct packed {
    logic             found;
    logic [IDX_W-1:0] match_index;
    logic [CNT_W-1:0] comparison_count;
  } lookup_t;

  logic signed [DATA_W-1:0] sorted_mem [TABLE_DEPTH];
  logic [TSIZE_W-1:0]       size_reg;
  lookup_t                  lookup_q [$];

  initial begin
    foreach (sorted_mem[i]) sorted_mem[i] = '0;
    size_reg = '0;
  end

  function automatic lookup_t predict_lookup(input logic signed [DATA_W-1:0] key);
    lookup_t r;
    int      lo;
    int      hi;
    int      mid;
    int      n;
    bit      done;
    r    = '0;
    done = 1'b0;
    n    = (size_reg > TABLE_DEPTH) ? TABLE_DEPTH : int'(size_reg);
    lo   = 0;
    hi   = n - 1;
    while (!done && lo <= hi) begin
      mid = lo + (hi - lo) / 2;
      r.comparison_count = r.comparison_count + 1'b1;
      if (sorted_mem[mid] == key) begin
        r.found       = 1'b1;
        r.match_index = IDX_W'(mid);
        done          = 1'b1;
      end else begin
        r.comparison_count = r.comparison_count + 1'b1;
        if (key < sorted_mem[mid]) begin
          hi = mid - 1;
        end else begin
          lo = mid + 1;
        end
      end
    end
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    lookup_t got;
    lookup_t want;
    if (!rst_ni) begin
      size_reg = '0;
      lookup_q.delete();
      pending_o    = 0;
      fail_count_o = 0;
    end else begin
      if (psel && penable && pwrite && pready && paddr[PADDR_W-1:2] == REG_TABLE_SIZE) begin
        size_reg = pwdata[TSIZE_W-1:0];
      end
      if (s_axis_tvalid_i && s_axis_tready_i) begin
        if (s_axis_tuser_i == FUNC_WRITE) begin
          sorted_mem[s_axis_tdata_i[9:0]] = s_axis_tdata_i[41:10];
        end else begin
          lookup_q.push_back(predict_lookup(s_axis_tdata_i[73:42]));
        end
      end
      if (m_axis_tvalid_i && m_axis_tready_i) begin
        got = {m_axis_tuser_i, m_axis_tdata_i[9:0], m_axis_tdata_i[14:10]};
        if (lookup_q.size() == 0) begin
          $error("result transfer with no search outstanding");
          fail_count_o++;
        end else begin
          want = lookup_q.pop_front();
          if (got.found !== want.found) begin
            $error("found: expected %0d, got %0d", want.found, got.found);
            fail_count_o++;
          end
          if (got.match_index !== want.match_index) begin
            $error("match_index: expected %0d, got %0d", want.match_index, got.match_index);
            fail_count_o++;
          end
          if (got.comparison_count !== want.comparison_count) begin
            $error("comparison_count: expected %0d, got %0d",
                   want.comparison_count, got.comparison_count);
            fail_count_o++;
          end
        end
      end
      pending_o = lookup_q.size();
    end
  end

endmodule

// File: verif/binary_search_with_probe_count_top_test.sv
`timescale 1ns / 100ps

module binary_search_with_probe_count_top_test;
  import bs_pkg::*;

  localparam int          SETTLE_CYCLES = 40;
  localparam logic [31:0] VAL_MIN       = 32'h8000_0000;
  localparam logic [31:0] VAL_MAX       = 32'h7fff_ffff;

  logic               clk_i         = 1'b0;
  logic               rst_ni        = 1'b0;
  logic               s_axis_tvalid = 1'b0;
  logic               s_axis_tready;
  logic [79:0]        s_axis_tdata  = '0;
  logic               s_axis_tuser  = 1'b0;
  logic               m_axis_tvalid;
  logic               m_axis_tready = 1'b0;
  logic [15:0]        m_axis_tdata;
  logic               m_axis_tuser;
  logic               psel          = 1'b0;
  logic               penable       = 1'b0;
  logic               pwrite        = 1'b0;
  logic [PADDR_W-1:0] paddr         = '0;
  logic [31:0]        pwdata        = '0;
  logic [31:0]        prdata;
  logic               pready;

  int          mismatches;
  int          pending;
  int          items_sent  = 0;
  int unsigned tx_idle_pct = 14;
  int unsigned rx_idle_pct = 50;
  logic [31:0] shadow_mem [TABLE_DEPTH];

  binary_search_with_probe_count_top i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid),
    .s_axis_tready_o (s_axis_tready),
    .s_axis_tdata_i  (s_axis_tdata),
    .s_axis_tuser_i  (s_axis_tuser),
    .m_axis_tvalid_o (m_axis_tvalid),
    .m_axis_tready_i (m_axis_tready),
    .m_axis_tdata_o  (m_axis_tdata),
    .m_axis_tuser_o  (m_axis_tuser),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready)
  );

  binary_search_monitor i_monitor (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid),
    .s_axis_tready_i (s_axis_tready),
    .s_axis_tdata_i  (s_axis_tdata),
    .s_axis_tuser_i  (s_axis_tuser),
    .m_axis_tvalid_i (m_axis_tvalid),
    .m_axis_tready_i (m_axis_tready),
    .m_axis_tdata_i  (m_axis_tdata),
    .m_axis_tuser_i  (m_axis_tuser),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .pready          (pready),
    .fail_count_o    (mismatches),
    .pending_o       (pending)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  always @(negedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
  end

  initial begin
    #10_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  task automatic send_item(input logic func, input logic [9:0] idx,
                           input logic [31:0] val, input logic [31:0] key);
    @(negedge clk_i);
    while ($urandom_range(99) < tx_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= func;
    s_axis_tdata  <= {6'b0, key, val, idx};
    do @(posedge clk_i); while (!s_axis_tready);
    if (func == FUNC_WRITE) shadow_mem[idx] = val;
    items_sent++;
  endtask

  task automatic write_entry(input logic [9:0] idx, input logic [31:0] val);
    send_item(FUNC_WRITE, idx, val, $urandom);
  endtask

  task automatic search(input logic [31:0] key);
    send_item(FUNC_SEARCH, 10'($urandom), $urandom, key);
  endtask

  task automatic wait_drained(input bit settle);
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    if (settle) repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic set_table_size(input int unsigned size);
    wait_drained(1'b1);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {REG_TABLE_SIZE, 2'b00};
    pwdata  <= size;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // ascending fill unless scrambled, dense steps give runs of duplicates
  task automatic load_table(input int n, input bit scrambled, input bit dense);
    longint      level;
    int unsigned step;
    step = dense ? 3 : 32'hffff_ffff / (n + 1);
    if (dense) begin
      level = -64'sd2147483648 + longint'($urandom_range(32'h7fff_ffff));
    end else begin
      level = -64'sd2147483648 + longint'($urandom_range(step));
    end
    for (int i = 0; i < n; i++) begin
      write_entry(10'(i), scrambled ? $urandom : level[31:0]);
      level += longint'($urandom_range(step));
    end
  endtask

  function automatic logic [31:0] pick_key(input int n);
    int unsigned r;
    r = $urandom_range(99);
    if (n > 0 && r < 55) return shadow_mem[$urandom_range(n - 1)];
    if (n > 0 && r < 75) begin
      return shadow_mem[$urandom_range(n - 1)] + ($urandom_range(1) ? 32'd1 : 32'hffff_ffff);
    end
    if (r < 87) return $urandom_range(1) ? VAL_MIN : VAL_MAX;
    return $urandom;
  endfunction

  task automatic run_phase(input int unsigned size, input int searches, input bit reload);
    int          n;
    int unsigned r;
    n = (size > TABLE_DEPTH) ? TABLE_DEPTH : size;
    set_table_size(size);
    if (reload) load_table(n, $urandom_range(9) == 0, $urandom_range(3) == 0);
    for (int k = 0; k < searches; k++) begin
      r = $urandom_range(99);
      if (r < 12 && n < TABLE_DEPTH) begin
        // stray writes outside the searched range
        write_entry(10'($urandom_range(TABLE_DEPTH - 1, n)), $urandom);
      end else begin
        if (r >= 97) wait_drained(1'b0);
        search(pick_key(n));
      end
    end
  endtask

  task automatic small_phase();
    int unsigned r;
    int unsigned n;
    r = $urandom_range(99);
    if (r < 5) begin
      n = 0;
    end else if (r < 75) begin
      n = $urandom_range(16, 1);
    end else if (r < 95) begin
      n = $urandom_range(64, 17);
    end else begin
      n = $urandom_range(200, 65);
    end
    run_phase(n, $urandom_range(n + 6, n / 2 + 2), 1'b1);
  endtask

  initial begin
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // empty table after reset
    search(VAL_MIN);
    search(32'd0);

    write_entry(10'd0, VAL_MIN);
    write_entry(10'd1, 32'(-1000));
    write_entry(10'd2, 32'(-5));
    write_entry(10'd3, 32'd0);
    write_entry(10'd4, 32'd0);
    write_entry(10'd5, 32'd42);
    write_entry(10'd6, 32'd1000000);
    write_entry(10'd7, VAL_MAX);
    write_entry(10'h3ff, $urandom);
    set_table_size(8);
    search(VAL_MIN);
    search(VAL_MAX);
    search(32'(-5));
    search(32'd0);
    search(32'd42);
    search(32'd1);
    search(32'(-6));
    search(32'd1000000);
    set_table_size(1);
    search(VAL_MIN);
    search(VAL_MAX);

    while (items_sent < 250) small_phase();

    tx_idle_pct = 50;
    rx_idle_pct = 14;
    run_phase(TABLE_DEPTH, 60, 1'b1);
    run_phase(2047, 20, 1'b0);
    run_phase(TABLE_DEPTH + 1 + $urandom_range(1021), 20, 1'b0);
    while (items_sent < 1420) small_phase();

    tx_idle_pct = 0;
    rx_idle_pct = 0;
    while (items_sent < 1530) small_phase();

    wait_drained(1'b1);
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
